// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/rltc_pkg.sv =====
`timescale 1ns / 1ps

package rltc_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_APPEND  = 2'd1,
        OP_START   = 2'd2,
        OP_ADVANCE = 2'd3
    } t_op;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_PAST_END    = 3'd1;
    localparam logic [2:0] ST_EMPTY       = 3'd2;
    localparam logic [2:0] ST_FULL        = 3'd3;
    localparam logic [2:0] ST_NOT_STARTED = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] run_count;
        logic [31:0] run_value;
        logic [31:0] step_samples;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] current_value;
        logic [31:0] left_in_run;
        logic [63:0] time_total;
        logic [10:0] run_position;
    } t_out;

    // request after decode: arg_a is count or step, arg_b is value
    typedef struct packed {
        t_op         op;
        logic [31:0] arg_a;
        logic [31:0] arg_b;
    } t_cmd;

endpackage

// ===== design/rltc_front.sv =====
`timescale 1ns / 1ps

module rltc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  rltc_pkg::t_in    i_in,
    output logic             o_cmd_valid,
    input  logic             i_cmd_stall,
    output rltc_pkg::t_cmd   o_cmd
);

    rltc_pkg::t_cmd r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    logic           pop;
    rltc_pkg::t_cmd cmd_in;

    always_comb begin
        cmd_in.op = rltc_pkg::t_op'(i_in.opcode);
        if (cmd_in.op == rltc_pkg::OP_ADVANCE) begin
            cmd_in.arg_a = i_in.step_samples;
        end else begin
            cmd_in.arg_a = i_in.run_count;
        end
        cmd_in.arg_b = i_in.run_value;
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && !i_cmd_stall;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== design/rltc_back.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rltc_back #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    output logic             o_cmd_stall,
    input  rltc_pkg::t_cmd   i_cmd,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output rltc_pkg::t_out   o_out
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_ADV  = 5'b00100,
        S_ACC  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    logic [63:0] r_mem [TABLE_DEPTH];
    logic [63:0] r_rd_data;

    t_state      r_state, n_state;
    logic [IW-1:0] r_loaded, n_loaded;
    logic [IW-1:0] r_cursor, n_cursor;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_val, n_val;
    logic [63:0] r_acc, n_acc;
    logic        r_started, n_started;
    logic [31:0] r_n, n_n;
    logic [63:0] r_prod, n_prod;
    logic        r_cross, n_cross;
    logic [2:0]  r_status, n_status;
    logic        r_out_valid, n_out_valid;
    rltc_pkg::t_out r_out, n_out;

    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [IW:0]   cur_inc;
    logic          take;
    logic          out_free;
    logic          ge;
    logic [31:0]   mul_a;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign take        = i_cmd_valid && (r_state == S_IDLE);
    assign o_cmd_stall = (r_state != S_IDLE);
    assign cur_inc     = {1'b0, r_cursor} + (IW + 1)'(1);
    assign ge          = (r_n >= r_rem);
    assign mul_a       = ge ? r_rem : r_n;

    always_comb begin
        n_state     = r_state;
        n_loaded    = r_loaded;
        n_cursor    = r_cursor;
        n_rem       = r_rem;
        n_val       = r_val;
        n_acc       = r_acc;
        n_started   = r_started;
        n_n         = r_n;
        n_prod      = r_prod;
        n_cross     = r_cross;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_status = rltc_pkg::ST_OK;
                    n_state  = S_DONE;
                    case (i_cmd.op)
                        rltc_pkg::OP_CLEAR: begin
                            n_loaded  = '0;
                            n_cursor  = '0;
                            n_rem     = '0;
                            n_val     = '0;
                            n_started = 1'b0;
                        end
                        rltc_pkg::OP_APPEND: begin
                            if (r_loaded >= IW'(TABLE_DEPTH)) begin
                                n_status = rltc_pkg::ST_FULL;
                            end else begin
                                wr_en    = 1'b1;
                                n_loaded = r_loaded + IW'(1);
                            end
                        end
                        rltc_pkg::OP_START: begin
                            n_cursor = '0;
                            n_acc    = '0;
                            if (r_loaded == '0) begin
                                n_status  = rltc_pkg::ST_EMPTY;
                                n_started = 1'b0;
                                n_rem     = '0;
                                n_val     = '0;
                            end else begin
                                n_started = 1'b1;
                                rd_en     = 1'b1;
                                n_state   = S_LOAD;
                            end
                        end
                        default: begin
                            if (!r_started) begin
                                n_status = rltc_pkg::ST_NOT_STARTED;
                            end else begin
                                n_n     = i_cmd.arg_a;
                                n_state = S_ADV;
                            end
                        end
                    endcase
                end
            end
            S_LOAD: begin
                n_rem   = r_rd_data[63:32];
                n_val   = r_rd_data[31:0];
                n_state = S_DONE;
            end
            S_ADV: begin
                n_prod  = 64'(mul_a) * 64'(r_val);
                n_cross = 1'b0;
                n_state = S_ACC;
                if (ge) begin
                    n_n = r_n - r_rem;
                    if (cur_inc >= {1'b0, r_loaded}) begin
                        n_cursor = r_loaded;
                        n_rem    = 32'd1;
                        n_status = rltc_pkg::ST_PAST_END;
                    end else begin
                        n_cursor = cur_inc[IW-1:0];
                        rd_en    = 1'b1;
                        rd_addr  = cur_inc[AW-1:0];
                        n_cross  = 1'b1;
                    end
                end else begin
                    n_rem = r_rem - r_n;
                end
            end
            S_ACC: begin
                n_acc = r_acc + r_prod;
                if (r_cross) begin
                    n_rem   = r_rd_data[63:32];
                    n_val   = r_rd_data[31:0];
                    n_state = S_ADV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.status        = r_status;
                    n_out.current_value = r_val;
                    n_out.left_in_run   = r_rem;
                    n_out.time_total    = r_acc;
                    n_out.run_position  = 11'(r_cursor);
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_loaded[AW-1:0]] <= {i_cmd.arg_a, i_cmd.arg_b};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_prod   <= n_prod;
        r_cross  <= n_cross;
        r_status <= n_status;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_loaded    <= '0;
            r_cursor    <= '0;
            r_rem       <= '0;
            r_val       <= '0;
            r_acc       <= '0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_loaded    <= n_loaded;
            r_cursor    <= n_cursor;
            r_rem       <= n_rem;
            r_val       <= n_val;
            r_acc       <= n_acc;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `ASSERT_ALWAYS(a_cursor_in_table, i_clk, i_rst_n, r_cursor <= r_loaded)
    `ASSERT_IMPLIES(a_write_has_room, i_clk, i_rst_n, wr_en, r_loaded < IW'(TABLE_DEPTH))
    `ASSERT_NEXT(a_result_from_done, i_clk, i_rst_n, !o_out_valid && r_state != S_DONE, !o_out_valid)

endmodule

// ===== design/run_length_time_table_cursor.sv =====
`timescale 1ns / 1ps

// run-length table cursor: holds (sample count, per-sample value) entries
// input channel: i_in_valid / o_in_stall with a request in i_in; opcode
//   clears the table, appends an entry, starts the cursor or advances it
// output channel: o_out_valid / i_out_stall, exactly one result per request
//   carrying status, entry value, samples left, 64-bit time sum and position
// a two-entry queue sits behind the input, so requests are taken while the
//   back end is busy or a result is waiting
// back end steps: clear, append and rejected requests go straight from
//   idle to the result state, a start adds one table read, and an advance
//   runs the multiply and accumulate states once plus once per run crossed
//   (one table read and one multiply-accumulate per run); the back end takes
//   a new request only after its result is in the output register
// reset (synchronous, active low) empties the table and queue, clears the
//   cursor and time sum; table contents themselves are not cleared
// a stalled result holds in the output register and the back end waits
//   for it; the queue then fills and o_in_stall rises

module run_length_time_table_cursor #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  rltc_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output rltc_pkg::t_out  o_out
);

    logic           cmd_valid;
    logic           cmd_stall;
    rltc_pkg::t_cmd cmd;

    rltc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .i_cmd_stall (cmd_stall),
        .o_cmd       (cmd)
    );

    rltc_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_stall (cmd_stall),
        .i_cmd       (cmd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import rltc_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int RANDOM_ITEMS = 500;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef struct {
        t_in req;
        bit  wait_drain;
    } cursor_request_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_in  in_req = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_res;

    cursor_request_t pending_requests[$];
    t_out expected_cursor_results[$];

    // shadow of the cursor and its table
    logic [31:0] shadow_count [TABLE_DEPTH];
    logic [31:0] shadow_value [TABLE_DEPTH];
    int unsigned shadow_loaded = 0;
    int unsigned shadow_index = 0;
    logic [31:0] shadow_left = '0;
    logic [31:0] shadow_cur_value = '0;
    logic [63:0] shadow_total = '0;
    bit shadow_started = 1'b0;

    int errors = 0;
    int results_seen = 0;
    int random_items = 0;
    bit in_fire = 1'b0;
    int tx_gap = 0;
    int rx_left = 0;
    bit rx_mode = 1'b0;
    bit long_hold_done = 1'b0;
    int rx_pick;

    run_length_time_table_cursor #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_req),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_res)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic t_out compute_cursor_result(t_in req);
        t_out res;
        logic [31:0] n;
        bit done;
        res.status = ST_OK;
        case (t_op'(req.opcode))
            OP_CLEAR: begin
                shadow_loaded = 0;
                shadow_index = 0;
                shadow_left = '0;
                shadow_cur_value = '0;
                shadow_started = 1'b0;
            end
            OP_APPEND: begin
                if (shadow_loaded >= TABLE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_count[shadow_loaded] = req.run_count;
                    shadow_value[shadow_loaded] = req.run_value;
                    shadow_loaded++;
                end
            end
            OP_START: begin
                shadow_index = 0;
                shadow_total = '0;
                if (shadow_loaded == 0) begin
                    res.status = ST_EMPTY;
                    shadow_started = 1'b0;
                    shadow_left = '0;
                    shadow_cur_value = '0;
                end else begin
                    shadow_started = 1'b1;
                    shadow_left = shadow_count[0];
                    shadow_cur_value = shadow_value[0];
                end
            end
            default: begin
                if (!shadow_started) begin
                    res.status = ST_NOT_STARTED;
                end else begin
                    n = req.step_samples;
                    done = 1'b0;
                    while (!done && n >= shadow_left) begin
                        n -= shadow_left;
                        shadow_total += 64'(shadow_left) * 64'(shadow_cur_value);
                        if (shadow_index + 1 >= shadow_loaded) begin
                            shadow_index = shadow_loaded;
                            shadow_left = 32'd1;
                            res.status = ST_PAST_END;
                            done = 1'b1;
                        end else begin
                            shadow_index++;
                            shadow_left = shadow_count[shadow_index];
                            shadow_cur_value = shadow_value[shadow_index];
                        end
                    end
                    if (!done) begin
                        shadow_left -= n;
                        shadow_total += 64'(n) * 64'(shadow_cur_value);
                    end
                end
            end
        endcase
        res.current_value = shadow_cur_value;
        res.left_in_run = shadow_left;
        res.time_total = shadow_total;
        res.run_position = shadow_index[10:0];
        return res;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // accept requests and check results
    always @(posedge clk) begin
        t_out want;
        in_fire = rst_n && in_valid && !in_stall;
        if (in_fire) begin
            expected_cursor_results.push_back(compute_cursor_result(in_req));
        end
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (expected_cursor_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %0h", $time, out_res);
            end else begin
                want = expected_cursor_results.pop_front();
                check_field("status", want.status, out_res.status);
                check_field("current_value", want.current_value, out_res.current_value);
                check_field("left_in_run", want.left_in_run, out_res.left_in_run);
                check_field("time_total", want.time_total, out_res.time_total);
                check_field("run_position", want.run_position, out_res.run_position);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // request driver
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fire) begin
            if (tx_gap > 0) begin
                tx_gap--;
                in_valid <= 1'b0;
            end else if (pending_requests.size() != 0 &&
                         !(pending_requests[0].wait_drain &&
                           expected_cursor_results.size() != 0)) begin
                in_req <= pending_requests[0].req;
                in_valid <= 1'b1;
                pending_requests.pop_front();
                tx_gap = pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result stall pattern, with one long hold once traffic is flowing
    always @(negedge clk) begin
        if (rx_left == 0) begin
            if (!long_hold_done && results_seen >= 60) begin
                rx_mode = 1'b1;
                rx_left = 150;
                long_hold_done = 1'b1;
            end else begin
                rx_pick = $urandom_range(0, 99);
                if (rx_pick < 55) begin
                    rx_mode = 1'b0;
                    rx_left = $urandom_range(1, 20);
                end else if (rx_pick < 62) begin
                    rx_mode = 1'b0;
                    rx_left = $urandom_range(40, 150);
                end else if (rx_pick < 92) begin
                    rx_mode = 1'b1;
                    rx_left = $urandom_range(1, 3);
                end else if (rx_pick < 99) begin
                    rx_mode = 1'b1;
                    rx_left = $urandom_range(4, 12);
                end else begin
                    rx_mode = 1'b1;
                    rx_left = $urandom_range(20, 50);
                end
            end
        end
        rx_left--;
        out_stall <= rx_mode;
    end

    task automatic push_req(t_op op, logic [31:0] cnt, logic [31:0] val,
                            logic [31:0] step, bit drain);
        cursor_request_t item;
        item.req.opcode = op;
        item.req.run_count = cnt;
        item.req.run_value = val;
        item.req.step_samples = step;
        item.wait_drain = drain;
        pending_requests.push_back(item);
    endtask

    function automatic logic [31:0] rand_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 60) return $urandom_range(1, 4);
        if (r < 85) return $urandom_range(5, 100);
        if (r < 95) return $urandom;
        return ALL_ONES;
    endfunction

    function automatic logic [31:0] rand_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom;
        if (r < 90) return $urandom_range(0, 10);
        if (r < 95) return ALL_ONES;
        return '0;
    endfunction

    function automatic logic [31:0] rand_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 30) return 32'd1;
        if (r < 70) return $urandom_range(2, 20);
        if (r < 85) return $urandom_range(21, 500);
        if (r < 95) return $urandom;
        return ALL_ONES;
    endfunction

    initial begin
        int k;
        int m;
        // directed
        push_req(OP_ADVANCE, $urandom, $urandom, ALL_ONES, 1'b0);
        push_req(OP_START, '0, '0, '0, 1'b0);
        push_req(OP_ADVANCE, '0, '0, 32'd1, 1'b0);
        push_req(OP_APPEND, '0, ALL_ONES, '0, 1'b0);
        push_req(OP_APPEND, ALL_ONES, ALL_ONES, '0, 1'b0);
        push_req(OP_APPEND, 32'd1, '0, ALL_ONES, 1'b0);
        push_req(OP_START, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1);
        push_req(OP_ADVANCE, '0, '0, '0, 1'b0);
        push_req(OP_ADVANCE, '0, '0, 32'd1, 1'b0);
        push_req(OP_ADVANCE, '0, '0, ALL_ONES, 1'b0);
        push_req(OP_ADVANCE, '0, '0, 32'd1, 1'b0);
        push_req(OP_START, '0, '0, '0, 1'b0);
        push_req(OP_APPEND, 32'd5, 32'd7, '0, 1'b0);
        push_req(OP_ADVANCE, '0, '0, ALL_ONES, 1'b0);
        push_req(OP_ADVANCE, '0, '0, 32'd1, 1'b0);
        push_req(OP_ADVANCE, '0, '0, 32'd5, 1'b0);
        push_req(OP_CLEAR, ALL_ONES, ALL_ONES, ALL_ONES, 1'b0);
        push_req(OP_ADVANCE, '0, '0, 32'd3, 1'b0);
        push_req(OP_START, '0, '0, '0, 1'b0);

        // fill the table to the top, overflow it and run off the end
        push_req(OP_CLEAR, '0, '0, '0, 1'b1);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            push_req(OP_APPEND, $urandom_range(0, 3), $urandom, $urandom, 1'b0);
        end
        push_req(OP_APPEND, 32'd1, 32'd1, '0, 1'b0);
        push_req(OP_START, '0, '0, '0, 1'b0);
        push_req(OP_ADVANCE, '0, '0, 32'd100, 1'b0);
        push_req(OP_ADVANCE, '0, '0, ALL_ONES, 1'b0);
        push_req(OP_CLEAR, '0, '0, '0, 1'b0);

        // random sequences with some noise
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 80) begin
                if ($urandom_range(0, 99) < 80) begin
                    push_req(OP_CLEAR, $urandom, $urandom, $urandom,
                             $urandom_range(0, 99) < 20);
                    random_items++;
                end
                k = $urandom_range(1, 8);
                for (int i = 0; i < k; i++) begin
                    push_req(OP_APPEND, rand_count(), rand_value(), $urandom, 1'b0);
                end
                push_req(OP_START, $urandom, $urandom, $urandom, 1'b0);
                random_items += k + 1;
                m = $urandom_range(1, 10);
                for (int i = 0; i < m; i++) begin
                    if ($urandom_range(0, 99) < 10) begin
                        push_req(OP_APPEND, rand_count(), rand_value(), $urandom, 1'b0);
                        random_items++;
                    end
                    push_req(OP_ADVANCE, $urandom, $urandom, rand_step(), 1'b0);
                    random_items++;
                end
            end else begin
                k = $urandom_range(1, 4);
                for (int i = 0; i < k; i++) begin
                    push_req(t_op'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                             1'b0);
                end
                random_items += k;
            end
        end

        wait (pending_requests.size() == 0 && !in_valid &&
              expected_cursor_results.size() == 0);
        repeat (40) @(posedge clk);
        if (errors == 0 && expected_cursor_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== run_length_time_table_cursor.f =====
+incdir+design
design/rltc_pkg.sv
design/rltc_front.sv
design/rltc_back.sv
design/run_length_time_table_cursor.sv
tb/tb_top.sv
